// ===== hw/rtl/sorted_ring_priority_queue_top_macros.svh =====
// Assertion helpers for the sorted ring priority queue.
`ifndef SORTED_RING_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_RING_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SRPQ_ASSERT_NOW(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("srpq same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SRPQ_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("srpq next-cycle check failed");

`endif

// ===== hw/rtl/srpq_pkg.sv =====
`timescale 1ns / 1ps

package srpq_pkg;

    typedef enum logic [1:0] {
        MODE_POP    = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_APPEND = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] prio;
    } entry_t;

    // Per-slot command from the sequencer; a load never comes with a move,
    // and at most one of take_prev and take_next is set.
    typedef struct packed {
        logic load_val;
        logic load_pri;
        logic take_prev;
        logic take_next;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/srpq_if.sv =====
`timescale 1ns / 1ps

interface srpq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] item_value;
    logic [7:0] item_priority;

    modport source (output valid, output mode, output item_value, output item_priority,
                    input ready);
    modport sink (input valid, input mode, input item_value, input item_priority,
                  output ready);
endinterface

interface srpq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] popped_value;
    logic [1:0] status;
    logic [3:0] entry_count;

    modport source (output valid, output popped_value, output status, output entry_count,
                    input ready);
    modport sink (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

// ===== hw/rtl/sorted_ring_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Sorted ring priority queue.
// in_ch carries one command per beat: mode (pop, priority insert, plain
// append), item_value and item_priority. out_ch returns exactly one result
// beat per command: popped_value, status and entry_count.
// The store is a ring of DEPTH slots, one cell per slot, and holds DEPTH-1
// entries. A pop or an append finishes at accept: its result is registered at
// the accept edge and shows on out_ch in the next cycle. A priority insert
// writes the tail cell at accept and then moves the entry toward the head
// one neighbor swap per cycle, so the block stays busy after accept until the
// walk stops at the head end or behind an entry with an equal or smaller number;
// an insert into an empty queue needs no walk and is not busy at all.
// The result beat is out already during that walk.
// A command is accepted only when no walk is in progress and the result
// register is empty or being drained in the same cycle; a stalled out_ch
// holds its beat and backs up in_ch.
// Reset clears head, tail, all stored priorities and the result valid flag;
// the block takes commands from the first cycle after reset.
`include "sorted_ring_priority_queue_top_macros.svh"

module sorted_ring_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    srpq_in_if.sink    in_ch,
    srpq_out_if.source out_ch
);
    import srpq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_BUBBLE = 2'b10
    } state_t;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
        ring_inc = (x == LAST) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] x);
        ring_dec = (x == '0) ? LAST : x - 1'b1;
    endfunction

    state_t          state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   rem_reg, rem_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      popped_reg, popped_next;
    status_t         status_reg, status_next;
    logic [3:0]      count_reg, count_next;

    cell_ctrl_t      ctrl    [DEPTH];
    entry_t          held    [DEPTH];
    logic            lt_prev [DEPTH];
    entry_t          load_entry;

    logic            in_acc;
    logic            out_free;
    logic [IW-1:0]   cnt;
    logic [IW-1:0]   cnt_after;
    logic [IW+3:0]   cnt_wide;
    logic            full;
    logic [IW-1:0]   head_inc;
    logic [IW-1:0]   tail_inc;
    logic [IW-1:0]   pos_prev;
    logic            wr_val;
    logic            wr_pri;
    logic            stop;
    logic            swap;
    mode_t           mode;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign mode         = mode_t'(in_ch.mode);

    assign cnt      = (tail_reg >= head_reg) ? tail_reg - head_reg
                                             : IW'(DEPTH) + tail_reg - head_reg;
    assign full     = (cnt == LAST);
    assign head_inc = ring_inc(head_reg);
    assign tail_inc = ring_inc(tail_reg);
    assign pos_prev = ring_dec(pos_reg);

    assign load_entry.value = in_ch.item_value;
    assign load_entry.prio  = in_ch.item_priority;

    assign stop = (rem_reg == '0) || !lt_prev[pos_reg];
    assign swap = (state_reg == ST_BUBBLE) && !stop;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        popped_next    = popped_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        wr_val         = 1'b0;
        wr_pri         = 1'b0;
        cnt_after      = cnt;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    popped_next    = '0;
                    status_next    = STATUS_DONE;
                    case (mode)
                        MODE_POP:
                        begin
                            if (cnt == '0)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                head_next   = head_inc;
                                popped_next = held[head_inc].value;
                                cnt_after   = cnt - 1'b1;
                            end
                        end
                        MODE_INSERT, MODE_APPEND:
                        begin
                            if (full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                tail_next = tail_inc;
                                wr_val    = 1'b1;
                                cnt_after = cnt + 1'b1;
                                if (mode == MODE_INSERT)
                                begin
                                    wr_pri = 1'b1;
                                    if (cnt != '0)
                                    begin
                                        state_next = ST_BUBBLE;
                                        pos_next   = tail_inc;
                                        rem_next   = cnt;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_DONE;
                        end
                    endcase
                    count_next = cnt_wide[3:0];
                end
            end
            ST_BUBBLE:
            begin
                if (stop)
                    state_next = ST_IDLE;
                else
                begin
                    pos_next = pos_prev;
                    rem_next = rem_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_wide = {4'b0000, cnt_after};

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            localparam int PREV = (k == 0) ? DEPTH - 1 : k - 1;
            localparam int NEXT = (k == DEPTH - 1) ? 0 : k + 1;

            assign ctrl[k].load_val  = wr_val && (tail_inc == IW'(k));
            assign ctrl[k].load_pri  = wr_pri && (tail_inc == IW'(k));
            assign ctrl[k].take_prev = swap && (pos_reg == IW'(k));
            assign ctrl[k].take_next = swap && (pos_prev == IW'(k));

            srpq_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl[k]),
                .load           (load_entry),
                .prev           (held[PREV]),
                .next           (held[NEXT]),
                .held           (held[k]),
                .less_than_prev (lt_prev[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.popped_value = popped_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.entry_count  = count_reg;

    `SRPQ_ASSERT_NOW(a_no_accept_in_walk, state_reg == ST_BUBBLE, !in_acc)
    `SRPQ_ASSERT_NEXT(a_accept_gives_beat, in_acc, out_valid_reg)
    `SRPQ_ASSERT_NOW(a_walk_stays_off_head, state_reg == ST_BUBBLE, pos_reg != head_reg)

endmodule

// ===== hw/rtl/srpq_cell.sv =====
`timescale 1ns / 1ps

module srpq_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srpq_pkg::cell_ctrl_t   ctrl,
    input  srpq_pkg::entry_t       load,
    input  srpq_pkg::entry_t       prev,
    input  srpq_pkg::entry_t       next,
    output srpq_pkg::entry_t       held,
    output logic                   less_than_prev
);
    import srpq_pkg::*;

    logic [7:0] value_reg;
    logic [7:0] value_next;
    logic [7:0] prio_reg;
    logic [7:0] prio_next;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.take_prev)
        begin
            value_next = prev.value;
            prio_next  = prev.prio;
        end
        else if (ctrl.take_next)
        begin
            value_next = next.value;
            prio_next  = next.prio;
        end
        else
        begin
            if (ctrl.load_val)
                value_next = load.value;
            if (ctrl.load_pri)
                prio_next = load.prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prio_reg <= '0;
        else
            prio_reg <= prio_next;
    end

    assign held.value     = value_reg;
    assign held.prio      = prio_reg;
    // Swap request toward the head: strictly smaller number moves forward.
    assign less_than_prev = prio_reg < prev.prio;

endmodule
